FILE: design/tte_pkg.sv
// Shared constants, types and command/status bundles for the tap tempo estimator.
package tte_pkg;

  localparam int unsigned HISTORY_DEPTH_DEF = 8;

  localparam int unsigned TIME_W    = 32;
  localparam int unsigned TIMEOUT_W = 16;
  localparam int unsigned BPM_W     = 9;
  localparam int unsigned HELD_W    = 4;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd2000;

  localparam logic [BPM_W-1:0] BPM_DEFAULT = 9'd120;
  localparam logic [BPM_W-1:0] BPM_MIN     = 9'd30;
  localparam logic [BPM_W-1:0] BPM_MAX     = 9'd300;

  // Twice the milliseconds per minute, for round-half-up division
  localparam int unsigned MS2_W       = 17;
  localparam int unsigned MS2_PER_MIN = 120000;

  // APB register map
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic [PADDR_W-1:0] REG_TIMEOUT = 3'd0;

  typedef struct packed {
    logic accept;    // capture the input transaction
    logic update;    // apply a tap to the history ring
    logic rd;        // read the oldest entry
    logic setup;     // load the divider
    logic div_step;  // one restoring division step
    logic load;      // move the result into the output register
  } tte_cmd_t;

  typedef struct packed {
    logic div_last;
    logic out_free;
  } tte_sts_t;

endpackage

FILE: design/tte_ctrl.sv
// Sequencing state machine for the tap tempo estimator.
module tte_ctrl
  import tte_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  tte_sts_t sts_i,
  output tte_cmd_t cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_UPDATE = 6'b000010,
    ST_READ   = 6'b000100,
    ST_SETUP  = 6'b001000,
    ST_DIVIDE = 6'b010000,
    ST_DONE   = 6'b100000
  } tte_state_e;

  tte_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = ST_READ;
      end
      ST_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_SETUP;
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

FILE: design/tte_dp.sv
// Datapath: tap history ring, span and numerator setup, serial divider, output register.
module tte_dp
  import tte_pkg::*;
#(
  parameter int unsigned HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tte_cmd_t             cmd_i,
  output tte_sts_t             sts_o,
  input  logic                 op_i,
  input  logic [TIME_W-1:0]    now_ms_i,
  input  logic [TIMEOUT_W-1:0] timeout_i,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output logic [BPM_W-1:0]     bpm_o,
  output logic                 tempo_valid_o,
  output logic [HELD_W-1:0]    taps_held_o
);

  localparam int unsigned SLOT_W = $clog2(HISTORY_DEPTH);
  localparam int unsigned CNT_W  = $clog2(HISTORY_DEPTH + 1);
  localparam longint unsigned NUM_MAX =
    longint'(MS2_PER_MIN) * longint'(HISTORY_DEPTH - 1) + 64'hFFFF_FFFF;
  localparam int unsigned NUM_W  = $clog2(NUM_MAX + 1);
  localparam int unsigned DEN_W  = TIME_W + 1;
  localparam int unsigned REM_W  = DEN_W + 1;
  localparam int unsigned STEP_W = $clog2(NUM_W);
  localparam int unsigned PROD_W = MS2_W + CNT_W;

  logic                 op_q;
  logic [TIME_W-1:0]    now_q;
  logic [TIME_W-1:0]    newest_q;
  logic [SLOT_W-1:0]    slot_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [TIME_W-1:0]    tap_mem [HISTORY_DEPTH];
  logic [TIME_W-1:0]    old_q;
  logic                 dflt_q;
  logic [NUM_W-1:0]     quot_q;
  logic [REM_W-1:0]     rem_q;
  logic [DEN_W-1:0]     den_q;
  logic [STEP_W-1:0]    step_q;
  logic                 out_valid_q;
  logic [BPM_W-1:0]     bpm_q;
  logic                 tvalid_q;
  logic [HELD_W-1:0]    held_q;

  // Tap update
  logic [TIME_W-1:0] gap;
  logic              clr;
  logic [SLOT_W-1:0] slot_base, slot_inc;
  logic [CNT_W-1:0]  cnt_base, cnt_inc;

  assign gap       = now_q - newest_q;
  assign clr       = (cnt_q != '0) && (gap > TIME_W'(timeout_i));
  assign slot_base = clr ? '0 : slot_q;
  assign cnt_base  = clr ? '0 : cnt_q;
  assign slot_inc  = (slot_base == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : slot_base + 1'b1;
  assign cnt_inc   = (cnt_base == CNT_W'(HISTORY_DEPTH)) ? cnt_base : cnt_base + 1'b1;

  // Oldest held entry sits cnt_q slots behind the write slot
  logic [CNT_W:0]    old_ext;
  logic [SLOT_W-1:0] old_idx;

  always_comb begin
    old_ext = (CNT_W+1)'(slot_q) - (CNT_W+1)'(cnt_q);
    if ((CNT_W+1)'(slot_q) < (CNT_W+1)'(cnt_q)) begin
      old_ext = old_ext + (CNT_W+1)'(HISTORY_DEPTH);
    end
  end
  assign old_idx = old_ext[SLOT_W-1:0];

  // Divider setup: q = (120000*(n-1) + span) / (2*span)
  logic [TIME_W-1:0] span;
  logic [CNT_W-1:0]  nm1;
  logic [PROD_W-1:0] prod;
  logic [NUM_W-1:0]  num;

  assign span = newest_q - old_q;
  assign nm1  = cnt_q - 1'b1;
  assign prod = PROD_W'(MS2_PER_MIN) * PROD_W'(nm1);
  assign num  = NUM_W'(span) + NUM_W'(prod);

  // Restoring division step
  logic [REM_W-1:0] shifted;
  logic             ge;

  assign shifted = {rem_q[REM_W-2:0], quot_q[NUM_W-1]};
  assign ge      = (shifted >= REM_W'(den_q));

  // Result
  logic [BPM_W-1:0]  bpm_d;
  logic [TIME_W-1:0] vgap;

  always_comb begin
    if (dflt_q) begin
      bpm_d = BPM_DEFAULT;
    end else if (quot_q < NUM_W'(BPM_MIN)) begin
      bpm_d = BPM_MIN;
    end else if (quot_q > NUM_W'(BPM_MAX)) begin
      bpm_d = BPM_MAX;
    end else begin
      bpm_d = quot_q[BPM_W-1:0];
    end
  end

  assign vgap = now_q - newest_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q  <= op_i;
      now_q <= now_ms_i;
    end
    if (cmd_i.update && op_q) begin
      tap_mem[slot_base] <= now_q;
      newest_q           <= now_q;
    end
    if (cmd_i.rd) begin
      old_q <= tap_mem[old_idx];
    end
    if (cmd_i.setup) begin
      dflt_q <= (cnt_q < CNT_W'(2)) || (span < TIME_W'(nm1));
      quot_q <= num;
      rem_q  <= '0;
      den_q  <= {span, 1'b0};
    end else if (cmd_i.div_step) begin
      quot_q <= {quot_q[NUM_W-2:0], ge};
      rem_q  <= ge ? shifted - REM_W'(den_q) : shifted;
    end
    if (cmd_i.load) begin
      bpm_q    <= bpm_d;
      tvalid_q <= (cnt_q >= CNT_W'(2)) && (vgap < TIME_W'(timeout_i));
      held_q   <= HELD_W'(cnt_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q      <= '0;
      cnt_q       <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.update && op_q) begin
        slot_q <= slot_inc;
        cnt_q  <= cnt_inc;
      end
      if (cmd_i.setup) begin
        step_q <= '0;
      end else if (cmd_i.div_step) begin
        step_q <= step_q + 1'b1;
      end
      if (cmd_i.load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.div_last = (step_q == STEP_W'(NUM_W - 1));
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o   = out_valid_q;
  assign bpm_o         = bpm_q;
  assign tempo_valid_o = tvalid_q;
  assign taps_held_o   = held_q;

  // A held result must never be overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> (!out_valid_q || !out_stall_i))
    else $error("output register overwritten while stalled");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(HISTORY_DEPTH))
    else $error("tap count above history depth");

  a_tap_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.update && op_q) |=> (newest_q == now_q) && (cnt_q != '0))
    else $error("tap not recorded");

  a_bpm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (bpm_q >= BPM_MIN) && (bpm_q <= BPM_MAX))
    else $error("tempo out of range");

endmodule

FILE: design/tap_tempo_estimator_core.sv
// Top level of the tap tempo estimator: APB register, controller and datapath.
// Each transaction (tap or poll) returns one result: the tempo in BPM, a validity
// flag and the number of taps held. The block works on one transaction at a time;
// it takes no new one until the result is loaded. NUM_W (33 bits up to a depth
// of 64) is the numerator width walked one bit per cycle by the restoring divider.
// A finished result waits in the output register, so a new transaction is taken
// meanwhile; while an earlier result is still held by the output stall, the
// finished one waits and the stall holds off the next acceptance. The 16-bit
// timeout register lives at APB address 0 and resets to 2000.
module tap_tempo_estimator_core
  import tte_pkg::*;
#(
  parameter int unsigned HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               op_i,
  input  logic [TIME_W-1:0]  now_ms_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [BPM_W-1:0]   bpm_o,
  output logic               tempo_valid_o,
  output logic [HELD_W-1:0]  taps_held_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [TIMEOUT_W-1:0] timeout_q;
  tte_cmd_t             cmd;
  tte_sts_t             sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RST;
    end else if (psel && penable && pwrite && (paddr == REG_TIMEOUT)) begin
      timeout_q <= pwdata[TIMEOUT_W-1:0];
    end
  end

  assign prdata = (paddr == REG_TIMEOUT) ? PDATA_W'(timeout_q) : '0;
  assign pready = 1'b1;

  tte_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tte_dp #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .op_i          (op_i),
    .now_ms_i      (now_ms_i),
    .timeout_i     (timeout_q),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .bpm_o         (bpm_o),
    .tempo_valid_o (tempo_valid_o),
    .taps_held_o   (taps_held_o)
  );

endmodule
